// ===== hw/rtl/ucrr_pkg.sv =====
// Package for the control request responder: codes, state types, descriptor ROM.
// Used by ucrr_ctrl, ucrr_datapath and usb_control_request_responder.
package ucrr_pkg;

	localparam int unsigned Ep0PacketBytes = 8;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ZLP = 2'd1;
	localparam logic [1:0] KIND_NODATA = 2'd2;

	localparam logic [1:0] ENUM_DEFAULT = 2'd0;
	localparam logic [1:0] ENUM_ADDRESSED = 2'd1;
	localparam logic [1:0] ENUM_CONFIGURED = 2'd2;

	localparam logic [7:0] REQ_GET_STATUS = 8'd0;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE = 8'd11;

	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	localparam logic [0:0] REG_VENDOR_ID = 1'd0;
	localparam logic [0:0] REG_PRODUCT_ID = 1'd1;

	// Sources of the byte stream.
	typedef enum logic [2:0] {
		SRC_DEVICE,
		SRC_CONFIG,
		SRC_LANG,
		SRC_MAKER,
		SRC_PRODUCT,
		SRC_REPORT,
		SRC_CFGVAL,
		SRC_ZERO
	} src_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STREAM,
		ST_SINGLE
	} state_t;

	// State update selected by the controller.
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_BUS_RESET,
		UPD_ADDRESS,
		UPD_CONFIG
	} upd_t;

	typedef struct packed {
		logic load;
		logic step;
		logic out_load;
		logic [1:0] kind;
		src_t src;
		logic [5:0] len;
		upd_t upd;
	} cmd_t;

	typedef struct packed {
		logic final_byte;
	} status_t;

	function automatic logic [7:0] rom_byte(input src_t src, input logic [5:0] k);
		logic [7:0] b;
		b = 8'h00;
		case (src)
			SRC_CONFIG: begin
				case (k)
					6'd0: b = 8'h09; 6'd1: b = 8'h02; 6'd2: b = 8'h29; 6'd3: b = 8'h00;
					6'd4: b = 8'h01; 6'd5: b = 8'h01; 6'd6: b = 8'h00; 6'd7: b = 8'h80;
					6'd8: b = 8'hFA; 6'd9: b = 8'h09; 6'd10: b = 8'h04; 6'd11: b = 8'h00;
					6'd12: b = 8'h00; 6'd13: b = 8'h02; 6'd14: b = 8'h03; 6'd15: b = 8'h00;
					6'd16: b = 8'h00; 6'd17: b = 8'h00; 6'd18: b = 8'h09; 6'd19: b = 8'h21;
					6'd20: b = 8'h00; 6'd21: b = 8'h01; 6'd22: b = 8'h00; 6'd23: b = 8'h01;
					6'd24: b = 8'h22; 6'd25: b = 8'd52; 6'd26: b = 8'h00; 6'd27: b = 8'h07;
					6'd28: b = 8'h05; 6'd29: b = 8'h01; 6'd30: b = 8'h03; 6'd31: b = 8'h08;
					6'd32: b = 8'h00; 6'd33: b = 8'h01; 6'd34: b = 8'h07; 6'd35: b = 8'h05;
					6'd36: b = 8'h82; 6'd37: b = 8'h03; 6'd38: b = 8'h08; 6'd39: b = 8'h00;
					6'd40: b = 8'h01;
					default: b = 8'h00;
				endcase
			end
			SRC_LANG: begin
				case (k)
					6'd0: b = 8'h04; 6'd1: b = 8'h03; 6'd2: b = 8'h09; 6'd3: b = 8'h04;
					default: b = 8'h00;
				endcase
			end
			SRC_MAKER: begin
				case (k)
					6'd0: b = 8'd26; 6'd1: b = 8'h03; 6'd2: b = "M"; 6'd4: b = "a";
					6'd6: b = "n"; 6'd8: b = "u"; 6'd10: b = "f"; 6'd12: b = "a";
					6'd14: b = "c"; 6'd16: b = "t"; 6'd18: b = "u"; 6'd20: b = "r";
					6'd22: b = "e"; 6'd24: b = "r";
					default: b = 8'h00;
				endcase
			end
			SRC_PRODUCT: begin
				case (k)
					6'd0: b = 8'd14; 6'd1: b = 8'h03; 6'd2: b = "D"; 6'd4: b = "e";
					6'd6: b = "v"; 6'd8: b = "i"; 6'd10: b = "c"; 6'd12: b = "e";
					default: b = 8'h00;
				endcase
			end
			SRC_REPORT: begin
				case (k)
					6'd0: b = 8'h06; 6'd1: b = 8'hA0; 6'd2: b = 8'hFF; 6'd3: b = 8'h09;
					6'd4: b = 8'h01; 6'd5: b = 8'hA1; 6'd6: b = 8'h01; 6'd7: b = 8'h09;
					6'd8: b = 8'h02; 6'd9: b = 8'hA1; 6'd10: b = 8'h00; 6'd11: b = 8'h06;
					6'd12: b = 8'hA1; 6'd13: b = 8'hFF; 6'd14: b = 8'h09; 6'd15: b = 8'h03;
					6'd16: b = 8'h09; 6'd17: b = 8'h04; 6'd18: b = 8'h15; 6'd19: b = 8'h80;
					6'd20: b = 8'h25; 6'd21: b = 8'h7F; 6'd22: b = 8'h35; 6'd23: b = 8'h00;
					6'd24: b = 8'h45; 6'd25: b = 8'hFF; 6'd26: b = 8'h75; 6'd27: b = 8'h08;
					6'd28: b = 8'h95; 6'd29: b = 8'h40; 6'd30: b = 8'h81; 6'd31: b = 8'h02;
					6'd32: b = 8'h09; 6'd33: b = 8'h05; 6'd34: b = 8'h09; 6'd35: b = 8'h06;
					6'd36: b = 8'h15; 6'd37: b = 8'h80; 6'd38: b = 8'h25; 6'd39: b = 8'h7F;
					6'd40: b = 8'h35; 6'd41: b = 8'h00; 6'd42: b = 8'h45; 6'd43: b = 8'hFF;
					6'd44: b = 8'h75; 6'd45: b = 8'h08; 6'd46: b = 8'h95; 6'd47: b = 8'h40;
					6'd48: b = 8'h91; 6'd49: b = 8'h02; 6'd50: b = 8'hC0; 6'd51: b = 8'hC0;
					default: b = 8'h00;
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/ucrr_ctrl.sv =====
// Controller of the control request responder: decodes a word and sequences output.
// Depends on ucrr_pkg.
module ucrr_ctrl
	import ucrr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic mode,
	input logic [7:0] request_type,
	input logic [7:0] request_code,
	input logic [15:0] request_value,
	input logic [15:0] request_length,
	input logic out_free,
	input status_t status,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [5:0] n_len;
	logic is_data;
	logic [1:0] kind;
	src_t src;
	upd_t upd;
	logic [7:0] dtype;
	logic [7:0] didx;

	assign dtype = request_value[15:8];
	assign didx = request_value[7:0];

	always_comb begin
		is_data = 1'b0;
		kind = KIND_NODATA;
		src = SRC_ZERO;
		upd = UPD_NONE;
		n_len = 6'd0;
		if (mode) begin
			upd = UPD_BUS_RESET;
		end else begin
			case (request_code)
				REQ_GET_DESCRIPTOR: begin
					case (dtype)
						DESC_DEVICE: begin
							is_data = 1'b1; src = SRC_DEVICE; n_len = 6'd18;
						end
						DESC_CONFIG: begin
							is_data = 1'b1; src = SRC_CONFIG; n_len = 6'd41;
						end
						DESC_STRING: begin
							if (didx == 8'd0) begin
								is_data = 1'b1; src = SRC_LANG; n_len = 6'd4;
							end else if (didx == 8'd1) begin
								is_data = 1'b1; src = SRC_MAKER; n_len = 6'd26;
							end else if (didx == 8'd2) begin
								is_data = 1'b1; src = SRC_PRODUCT; n_len = 6'd14;
							end
						end
						DESC_REPORT: begin
							is_data = 1'b1; src = SRC_REPORT; n_len = 6'd52;
						end
						default: is_data = 1'b0;
					endcase
				end
				REQ_SET_ADDRESS: begin
					kind = KIND_ZLP; upd = UPD_ADDRESS;
				end
				REQ_GET_CONFIGURATION: begin
					is_data = 1'b1; src = SRC_CFGVAL; n_len = 6'd1;
				end
				REQ_GET_STATUS: begin
					if (request_type[7]) begin
						is_data = 1'b1; n_len = 6'd2;
					end
				end
				REQ_SET_CONFIGURATION: begin
					kind = KIND_ZLP; upd = UPD_CONFIG;
				end
				REQ_GET_INTERFACE: begin
					is_data = 1'b1; n_len = 6'd1;
				end
				REQ_SET_INTERFACE: kind = KIND_ZLP;
				default: kind = KIND_NODATA;
			endcase
		end
		if (is_data) begin
			if (request_length < {10'd0, n_len}) begin
				n_len = request_length[5:0];
			end
			kind = (n_len == 6'd0) ? KIND_ZLP : KIND_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.src = src;
		cmd.len = n_len;
		cmd.kind = kind;
		cmd.upd = UPD_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.upd = upd;
					state_d = (kind == KIND_DATA) ? ST_STREAM : ST_SINGLE;
				end
			end
			ST_STREAM: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.step = 1'b1;
					cmd.kind = KIND_DATA;
					if (status.final_byte) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/ucrr_datapath.sv =====
// Datapath of the control request responder: device state, byte counter, output register.
// Depends on ucrr_pkg.
module ucrr_datapath
	import ucrr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output status_t status,
	input logic [15:0] request_value,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic out_free,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic end_of_packet,
	output logic last,
	output logic [6:0] address_now,
	output logic [1:0] device_state_now,
	output logic [7:0] configuration_now,
	output logic data_endpoints_on
);

	logic [15:0] vendor_q, product_q;
	logic [6:0] addr_q;
	logic [1:0] enum_q;
	logic [7:0] conf_q;
	logic ep_q;
	logic [5:0] cnt_q, len_q;
	src_t src_q;
	logic [1:0] kind_q;
	logic [7:0] byte_d;
	logic [5:0] cnt_inc;

	assign cnt_inc = cnt_q + 6'd1;
	assign status.final_byte = (cnt_inc == len_q);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		case (src_q)
			SRC_DEVICE: begin
				case (cnt_q)
					6'd0: byte_d = 8'h12; 6'd1: byte_d = 8'h01; 6'd2: byte_d = 8'h10;
					6'd3: byte_d = 8'h01; 6'd7: byte_d = 8'(Ep0PacketBytes);
					6'd8: byte_d = vendor_q[7:0]; 6'd9: byte_d = vendor_q[15:8];
					6'd10: byte_d = product_q[7:0]; 6'd11: byte_d = product_q[15:8];
					6'd12: byte_d = 8'h01; 6'd14: byte_d = 8'h01; 6'd15: byte_d = 8'h02;
					6'd17: byte_d = 8'h01;
					default: byte_d = 8'h00;
				endcase
			end
			SRC_CFGVAL: byte_d = conf_q;
			default: byte_d = rom_byte(src_q, cnt_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= 16'd39621;
			product_q <= 16'd19343;
			addr_q <= '0;
			enum_q <= ENUM_DEFAULT;
			conf_q <= '0;
			ep_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_VENDOR_ID) vendor_q <= cfg_data;
			if (cfg_we && cfg_index == REG_PRODUCT_ID) product_q <= cfg_data;
			case (cmd.upd)
				UPD_BUS_RESET: begin
					addr_q <= '0; enum_q <= ENUM_DEFAULT; conf_q <= '0; ep_q <= 1'b0;
				end
				UPD_ADDRESS: begin
					addr_q <= request_value[6:0];
					enum_q <= (request_value[6:0] != 7'd0) ? ENUM_ADDRESSED : ENUM_DEFAULT;
				end
				UPD_CONFIG: begin
					conf_q <= request_value[7:0];
					enum_q <= (request_value[7:0] != 8'd0) ? ENUM_CONFIGURED : ENUM_ADDRESSED;
					ep_q <= (request_value[7:0] != 8'd0);
				end
				default: ;
			endcase
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= '0;
			len_q <= cmd.len;
			src_q <= cmd.src;
			kind_q <= cmd.kind;
		end else if (cmd.step) begin
			cnt_q <= cnt_inc;
		end
		if (cmd.out_load) begin
			address_now <= addr_q;
			device_state_now <= enum_q;
			configuration_now <= conf_q;
			data_endpoints_on <= ep_q;
			result_kind <= kind_q;
			if (kind_q == KIND_DATA) begin
				data_byte <= byte_d;
				last <= status.final_byte;
				end_of_packet <= status.final_byte ||
					((cnt_inc & 6'(Ep0PacketBytes - 1)) == 6'd0);
			end else begin
				data_byte <= 8'h00;
				last <= 1'b1;
				end_of_packet <= (kind_q == KIND_ZLP);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.step |-> cnt_q < len_q)
		else $error("byte counter ran past length");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> out_free)
		else $error("output overwritten");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=>
		out_valid && $stable({result_kind, data_byte, end_of_packet, last}))
		else $error("output word changed while waiting");

endmodule

// ===== hw/rtl/usb_control_request_responder.sv =====
// Top level of the USB control request responder; joins controller and datapath.
// Depends on ucrr_pkg, ucrr_ctrl and ucrr_datapath.
// A word is decoded and loaded while the controller is idle; its result words then follow,
// one per cycle while the output is taken. The HID report descriptor gives the longest
// run, 52 result words; the descriptor byte counter in the datapath steps through it.
module usb_control_request_responder
	import ucrr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic mode,
	input logic [7:0] request_type,
	input logic [7:0] request_code,
	input logic [15:0] request_value,
	input logic [15:0] request_length,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic end_of_packet,
	output logic last,
	output logic [6:0] address_now,
	output logic [1:0] device_state_now,
	output logic [7:0] configuration_now,
	output logic data_endpoints_on
);

	cmd_t cmd;
	status_t status;
	logic out_free;

	ucrr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .mode, .request_type, .request_code,
		.request_value, .request_length, .out_free, .status, .cmd
	);

	ucrr_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .request_value, .cfg_we, .cfg_index, .cfg_data,
		.out_free, .out_valid, .out_ready, .result_kind, .data_byte, .end_of_packet,
		.last, .address_now, .device_state_now, .configuration_now, .data_endpoints_on
	);

endmodule

// ===== tb/usb_control_request_responder_tb.sv =====
// Self-checking testbench for usb_control_request_responder: predicts every result word
// of each request or bus reset and checks them in order. Depends on ucrr_pkg and the RTL.
module usb_control_request_responder_tb;
	import ucrr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic mode;
		logic [7:0] rtype;
		logic [7:0] code;
		logic [15:0] value;
		logic [15:0] wlen;
	} request_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_v;
		logic eop;
		logic lst;
		logic [6:0] addr;
		logic [1:0] dstate;
		logic [7:0] cfgval;
		logic ep_on;
	} answer_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic mode;
	logic [7:0] request_type, request_code;
	logic [15:0] request_value, request_length;
	logic out_valid, out_ready;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic end_of_packet, last;
	logic [6:0] address_now;
	logic [1:0] device_state_now;
	logic [7:0] configuration_now;
	logic data_endpoints_on;

	usb_control_request_responder DUT (.*);

	answer_t answers_due[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycles = 0;
	bit sender_idles = 1;
	bit receiver_idles = 1;
	bit hold_off = 0;
	bit hold_long = 0;

	logic [15:0] m_vendor, m_product;
	logic [6:0] m_addr;
	logic [1:0] m_state;
	logic [7:0] m_cfg;
	logic m_ep;

	localparam logic [7:0] CONFIG_DESC[41] = '{
		8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hFA,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00,
		8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01, 8'h22, 8'd52, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h03, 8'h08, 8'h00, 8'h01,
		8'h07, 8'h05, 8'h82, 8'h03, 8'h08, 8'h00, 8'h01};
	localparam logic [7:0] REPORT_DESC[52] = '{
		8'h06, 8'hA0, 8'hFF, 8'h09, 8'h01, 8'hA1, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h00,
		8'h06, 8'hA1, 8'hFF,
		8'h09, 8'h03, 8'h09, 8'h04, 8'h15, 8'h80, 8'h25, 8'h7F, 8'h35, 8'h00, 8'h45, 8'hFF,
		8'h75, 8'h08, 8'h95, 8'h40, 8'h81, 8'h02,
		8'h09, 8'h05, 8'h09, 8'h06, 8'h15, 8'h80, 8'h25, 8'h7F, 8'h35, 8'h00, 8'h45, 8'hFF,
		8'h75, 8'h08, 8'h95, 8'h40, 8'h91, 8'h02, 8'hC0, 8'hC0};
	localparam logic [7:0] LANG_DESC[4] = '{8'h04, 8'h03, 8'h09, 8'h04};
	localparam logic [7:0] MAKER_DESC[26] = '{8'd26, 8'h03, "M", 0, "a", 0, "n", 0,
		"u", 0, "f", 0, "a", 0, "c", 0, "t", 0, "u", 0, "r", 0, "e", 0, "r", 0};
	localparam logic [7:0] PRODUCT_DESC[14] = '{8'd14, 8'h03, "D", 0, "e", 0, "v", 0,
		"i", 0, "c", 0, "e", 0};

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic answer_t stamp(logic [1:0] kind, logic [7:0] b, logic eop, logic lst);
		answer_t a;
		a.kind = kind;
		a.byte_v = b;
		a.eop = eop;
		a.lst = lst;
		a.addr = m_addr;
		a.dstate = m_state;
		a.cfgval = m_cfg;
		a.ep_on = m_ep;
		return a;
	endfunction

	task automatic queue_stage(input logic [7:0] bytes[$], input logic [15:0] wlen);
		int count;
		count = (bytes.size() < wlen) ? bytes.size() : wlen;
		if (count == 0)
			answers_due.push_back(stamp(KIND_ZLP, 8'h00, 1'b1, 1'b1));
		for (int k = 0; k < count; k++)
			answers_due.push_back(stamp(KIND_DATA, bytes[k],
				((k + 1) % Ep0PacketBytes == 0) || (k + 1 == count), k + 1 == count));
	endtask

	task automatic predict_request(input request_t r);
		logic [7:0] bytes[$];
		logic [7:0] dtype, idx;
		dtype = r.value[15:8];
		idx = r.value[7:0];
		if (r.mode) begin
			m_addr = '0;
			m_state = ENUM_DEFAULT;
			m_cfg = '0;
			m_ep = 1'b0;
			answers_due.push_back(stamp(KIND_NODATA, 8'h00, 1'b0, 1'b1));
			return;
		end
		case (r.code)
			REQ_GET_DESCRIPTOR: begin
				if (dtype == DESC_DEVICE)
					bytes = '{8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00,
						8'(Ep0PacketBytes), m_vendor[7:0], m_vendor[15:8],
						m_product[7:0], m_product[15:8],
						8'h01, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01};
				else if (dtype == DESC_CONFIG)
					foreach (CONFIG_DESC[i]) bytes.push_back(CONFIG_DESC[i]);
				else if (dtype == DESC_STRING && idx == 8'd0)
					foreach (LANG_DESC[i]) bytes.push_back(LANG_DESC[i]);
				else if (dtype == DESC_STRING && idx == 8'd1)
					foreach (MAKER_DESC[i]) bytes.push_back(MAKER_DESC[i]);
				else if (dtype == DESC_STRING && idx == 8'd2)
					foreach (PRODUCT_DESC[i]) bytes.push_back(PRODUCT_DESC[i]);
				else if (dtype == DESC_REPORT)
					foreach (REPORT_DESC[i]) bytes.push_back(REPORT_DESC[i]);
				else begin
					answers_due.push_back(stamp(KIND_NODATA, 8'h00, 1'b0, 1'b1));
					return;
				end
				queue_stage(bytes, r.wlen);
			end
			REQ_SET_ADDRESS: begin
				m_addr = r.value[6:0];
				m_state = (m_addr != 0) ? ENUM_ADDRESSED : ENUM_DEFAULT;
				answers_due.push_back(stamp(KIND_ZLP, 8'h00, 1'b1, 1'b1));
			end
			REQ_GET_CONFIGURATION: begin
				bytes = '{m_cfg};
				queue_stage(bytes, r.wlen);
			end
			REQ_GET_STATUS: begin
				if (r.rtype[7]) begin
					bytes = '{8'h00, 8'h00};
					queue_stage(bytes, r.wlen);
				end else
					answers_due.push_back(stamp(KIND_NODATA, 8'h00, 1'b0, 1'b1));
			end
			REQ_SET_CONFIGURATION: begin
				m_cfg = r.value[7:0];
				m_state = (m_cfg != 0) ? ENUM_CONFIGURED : ENUM_ADDRESSED;
				m_ep = (m_cfg != 0);
				answers_due.push_back(stamp(KIND_ZLP, 8'h00, 1'b1, 1'b1));
			end
			REQ_GET_INTERFACE: begin
				bytes = '{8'h00};
				queue_stage(bytes, r.wlen);
			end
			REQ_SET_INTERFACE:
				answers_due.push_back(stamp(KIND_ZLP, 8'h00, 1'b1, 1'b1));
			default:
				answers_due.push_back(stamp(KIND_NODATA, 8'h00, 1'b0, 1'b1));
		endcase
	endtask

	task automatic send_word(input request_t r);
		int gap;
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		request_type <= r.rtype;
		request_code <= r.code;
		request_value <= r.value;
		request_length <= r.wlen;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(r);
		words_sent++;
	endtask

	function automatic request_t make(logic [7:0] code, logic [15:0] value, logic [15:0] wlen,
		logic [7:0] rtype = 8'h80);
		request_t r;
		r.mode = 1'b0;
		r.rtype = rtype;
		r.code = code;
		r.value = value;
		r.wlen = wlen;
		return r;
	endfunction

	function automatic request_t bus_reset_word();
		request_t r;
		r = request_t'({$urandom, $urandom});
		r.mode = 1'b1;
		return r;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_id(input logic [0:0] index, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_VENDOR_ID)
			m_vendor = value;
		else
			m_product = value;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("%0t timeout: %0d words still due", $time, answers_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || hold_off || hold_long)
			out_ready <= 1'b0;
		else if (receiver_idles && $urandom_range(0, 5) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (receiver_idles && !hold_off && $urandom_range(0, 15) == 0) begin
				n = $urandom_range(1, 12);
				hold_off <= 1'b1;
				repeat (n) @(posedge clk);
				hold_off <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, data_byte, end_of_packet, last, address_now,
				device_state_now, configuration_now, data_endpoints_on};
			words_checked++;
			if (answers_due.size() == 0) begin
				$display("%0t unexpected word: actual %h", $time, got);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected kind %0d byte %h eop %b last %b",
						$time, want.kind, want.byte_v, want.eop, want.lst);
					$display("  state expected addr %0d st %0d cfg %0d ep %b", want.addr,
						want.dstate, want.cfgval, want.ep_on);
					$display("  actual kind %0d byte %h eop %b last %b addr %0d st %0d",
						got.kind, got.byte_v, got.eop, got.lst, got.addr, got.dstate);
					$display("  actual cfg %0d ep %b", got.cfgval, got.ep_on);
				end
			end
		end
	end

	task automatic test_descriptors();
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0100, 16'hFFFF));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0200, 16'd41));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0200, 16'd16));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0300, 16'd9));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0301, 16'd255));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0302, 16'd3));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0303, 16'd64));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h03FF, 16'd64));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h22FF, 16'd1000));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0400, 16'd8));
		send_word(make(REQ_GET_DESCRIPTOR, 16'hFF00, 16'd8));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0100, 16'd0));
	endtask

	task automatic test_state_requests();
		send_word(make(REQ_SET_ADDRESS, 16'hFFFF, 16'd0, 8'h00));
		send_word(make(REQ_GET_STATUS, 16'h0000, 16'd2, 8'hFF));
		send_word(make(REQ_GET_STATUS, 16'h0000, 16'd1, 8'h7F));
		send_word(make(REQ_SET_CONFIGURATION, 16'h00FF, 16'hFFFF, 8'h00));
		send_word(make(REQ_GET_CONFIGURATION, 16'h0000, 16'd1));
		send_word(make(REQ_GET_INTERFACE, 16'h0000, 16'd0));
		send_word(make(REQ_SET_INTERFACE, 16'h0000, 16'd0, 8'h01));
		send_word(make(REQ_SET_CONFIGURATION, 16'h0000, 16'd0, 8'h00));
		send_word(make(REQ_SET_ADDRESS, 16'h0080, 16'd0, 8'h00));
		send_word(make(8'hFF, 16'h1234, 16'd7));
		send_word(bus_reset_word());
	endtask

	function automatic request_t random_request();
		request_t r;
		logic [7:0] codes[8] = '{REQ_GET_STATUS, REQ_SET_ADDRESS, REQ_GET_DESCRIPTOR,
			REQ_GET_DESCRIPTOR, REQ_GET_CONFIGURATION, REQ_SET_CONFIGURATION,
			REQ_GET_INTERFACE, REQ_SET_INTERFACE};
		logic [7:0] types[6] = '{DESC_DEVICE, DESC_CONFIG, DESC_STRING, DESC_STRING,
			DESC_REPORT, 8'h00};
		r = request_t'({$urandom, $urandom});
		r.mode = ($urandom_range(0, 11) == 0);
		if ($urandom_range(0, 9) != 0)
			r.code = codes[$urandom_range(0, 7)];
		if (r.code == REQ_GET_DESCRIPTOR && $urandom_range(0, 7) != 0) begin
			r.value[15:8] = types[$urandom_range(0, 5)];
			if ($urandom_range(0, 3) != 0)
				r.value[7:0] = 8'($urandom_range(0, 3));
		end
		case ($urandom_range(0, 4))
			0: r.wlen = 16'($urandom_range(0, 2));
			1, 2: r.wlen = 16'($urandom_range(0, 70));
			default: ;
		endcase
		return r;
	endfunction

	task automatic test_random(input int count);
		repeat (count) send_word(random_request());
	endtask

	task automatic test_backpressure();
		hold_long <= 1'b1;
		fork
			repeat (6) send_word(make(REQ_GET_DESCRIPTOR, 16'h2200, 16'hFFFF));
			begin
				repeat (300) @(posedge clk);
				hold_long <= 1'b0;
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		request_type = '0;
		request_code = '0;
		request_value = '0;
		request_length = '0;
		m_vendor = 16'd39621;
		m_product = 16'd19343;
		m_addr = '0;
		m_state = ENUM_DEFAULT;
		m_cfg = '0;
		m_ep = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_descriptors();
		test_state_requests();
		drain();
		write_id(REG_VENDOR_ID, 16'h0000);
		write_id(REG_PRODUCT_ID, 16'hFFFF);
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0100, 16'd18));
		test_random(60);
		drain();
		write_id(REG_VENDOR_ID, 16'hFFFF);
		write_id(REG_PRODUCT_ID, 16'h0000);
		test_backpressure();
		test_random(50);
		drain();
		write_id(REG_VENDOR_ID, 16'($urandom));
		write_id(REG_PRODUCT_ID, 16'($urandom));
		send_word(make(REQ_GET_DESCRIPTOR, 16'h0100, 16'd12));
		sender_idles = 0;
		receiver_idles = 0;
		test_random(40);
		drain();

		$display("Covered %0d request and bus reset words, %0d result words checked,",
			words_sent, words_checked);
		$display("with four identifier settings and a long receiver stall.");
		if (errors == 0 && answers_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/ucrr_pkg.sv
hw/rtl/ucrr_ctrl.sv
hw/rtl/ucrr_datapath.sv
hw/rtl/usb_control_request_responder.sv
tb/usb_control_request_responder_tb.sv
